FILE: design/vsks_pkg.sv
// shared types, constants and helpers for the vector sum key sorter
package vsks_pkg;

   localparam int COMP_W          = 24;
   localparam int NUM_COMPS       = 4;
   localparam int COMP_IDX_W      = 2;
   localparam int FRAC_W          = 8;
   localparam int KEY_W           = 19;
   localparam int ACC_W           = KEY_W + FRAC_W;
   localparam int DIM_W           = 3;
   localparam int POS_W           = 4;
   localparam int MAX_DIM         = 4;
   localparam int DIM_LIM         = (MAX_DIM < NUM_COMPS) ? MAX_DIM : NUM_COMPS;
   localparam int MAX_VECTORS_DEF = 16;

   localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef comp_type [NUM_COMPS-1:0] comp_array_type;
   typedef logic signed [KEY_W-1:0]  key_type;

   typedef struct packed {
      key_type        key;
      comp_array_type comps;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_SORT_INIT,
      ST_RD0,
      ST_LD,
      ST_CMP,
      ST_WB,
      ST_DRAIN
   } state_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(DIM_LIM);
      return (dim > lim) ? lim : dim;
   endfunction

endpackage

FILE: design/vector_sum_key_sorter_top.sv
// Collects vectors one item per start pulse taken while busy is low and, on an item
// marked last, bubble sorts them by their sum key and emits them in ascending order.
// A stored item keeps busy high while the key unit adds one component per cycle up
// to the effective dim (dim capped at 4); an item that arrives with the store full
// is dropped. After the last item the sorter goes through a setup state, then makes
// passes of length n down to 2 through the single read / single write port memory,
// one compare-swap per cycle; each pass loads the first entry, compare-swaps along
// the pass and writes the largest entry back at its end. Then n results follow one
// per cycle, each valid for exactly one cycle on rsp_valid. The receiver cannot
// stall, and busy stays high until the last result has been read out of the memory.
// The user must write dim only while busy is low; the block does not enforce it.
module vector_sum_key_sorter_top #(
   parameter int MAX_VECTORS = vsks_pkg::MAX_VECTORS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  vsks_pkg::comp_type            req_comp0,
   input  vsks_pkg::comp_type            req_comp1,
   input  vsks_pkg::comp_type            req_comp2,
   input  vsks_pkg::comp_type            req_comp3,
   input  logic                          req_last_vector,
   output logic                          rsp_valid,
   output vsks_pkg::comp_type            rsp_out_comp0,
   output vsks_pkg::comp_type            rsp_out_comp1,
   output vsks_pkg::comp_type            rsp_out_comp2,
   output vsks_pkg::comp_type            rsp_out_comp3,
   output logic [vsks_pkg::POS_W-1:0]    rsp_position,
   output logic                          rsp_last_out,
   input  logic                          csr_we,
   input  logic [vsks_pkg::DIM_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_VECTORS);
   localparam int CW = $clog2(MAX_VECTORS + 1);
   localparam int EW = $bits(vsks_pkg::entry_type);

   vsks_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [CW-1:0]              i_ff, i_in;
   logic [AW-1:0]              j_ff, j_in;
   logic [AW-1:0]              k_ff, k_in;
   logic                       last_pend_ff, last_pend_in;
   vsks_pkg::comp_array_type   vec_ff, vec_in;
   vsks_pkg::entry_type        cur_ff, cur_in;
   logic [vsks_pkg::DIM_W-1:0] dim_ff;
   logic                       emit_ff, emit_in;
   logic [vsks_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       lastr_ff, lastr_in;

   logic                       accept;
   logic                       key_start;
   logic                       key_done;
   vsks_pkg::key_type          key;
   logic [vsks_pkg::DIM_W-1:0] eff;
   logic [CW-1:0]              jp2;
   logic [CW-1:0]              kp1;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   vsks_pkg::entry_type        wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   vsks_pkg::entry_type        rd_data;
   vsks_pkg::comp_array_type   shown;

   assign busy   = (state_ff != vsks_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign eff    = vsks_pkg::eff_dim(dim_ff);
   assign jp2    = CW'(j_ff) + CW'(2);
   assign kp1    = CW'(k_ff) + CW'(1);

   vsks_key_unit u_key (
      .clock (clock),
      .reset (reset),
      .start (key_start),
      .eff   (eff),
      .comps (vec_ff),
      .done  (key_done),
      .key   (key)
   );

   vsks_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_VECTORS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vsks_pkg::ST_IDLE: begin
            if (accept) begin
               if (count_ff < CW'(MAX_VECTORS)) begin
                  state_in = vsks_pkg::ST_KEY;
               end else if (req_last_vector) begin
                  state_in = vsks_pkg::ST_SORT_INIT;
               end
            end
         end
         vsks_pkg::ST_KEY: begin
            if (key_done) begin
               state_in = last_pend_ff ? vsks_pkg::ST_SORT_INIT : vsks_pkg::ST_IDLE;
            end
         end
         vsks_pkg::ST_SORT_INIT: begin
            state_in = (count_ff > CW'(1)) ? vsks_pkg::ST_RD0 : vsks_pkg::ST_DRAIN;
         end
         vsks_pkg::ST_RD0: begin
            state_in = vsks_pkg::ST_LD;
         end
         vsks_pkg::ST_LD: begin
            state_in = vsks_pkg::ST_CMP;
         end
         vsks_pkg::ST_CMP: begin
            if (!(jp2 < i_ff)) begin
               state_in = vsks_pkg::ST_WB;
            end
         end
         vsks_pkg::ST_WB: begin
            state_in = (i_ff > CW'(2)) ? vsks_pkg::ST_RD0 : vsks_pkg::ST_DRAIN;
         end
         vsks_pkg::ST_DRAIN: begin
            if (kp1 == count_ff) begin
               state_in = vsks_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vsks_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      last_pend_in = last_pend_ff;
      vec_in       = vec_ff;
      cur_in       = cur_ff;
      emit_in      = 1'b0;
      pos_in       = pos_ff;
      lastr_in     = lastr_ff;
      key_start    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      case (state_ff)
         vsks_pkg::ST_IDLE: begin
            if (accept) begin
               vec_in       = {req_comp3, req_comp2, req_comp1, req_comp0};
               last_pend_in = req_last_vector;
               key_start    = (count_ff < CW'(MAX_VECTORS));
            end
         end
         vsks_pkg::ST_KEY: begin
            if (key_done) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(count_ff);
               wr_data  = '{key: key, comps: vec_ff};
               count_in = count_ff + CW'(1);
            end
         end
         vsks_pkg::ST_SORT_INIT: begin
            i_in = count_ff;
            k_in = '0;
         end
         vsks_pkg::ST_RD0: begin
            rd_en   = 1'b1;
            rd_addr = '0;
         end
         vsks_pkg::ST_LD: begin
            cur_in  = rd_data;
            rd_en   = 1'b1;
            rd_addr = AW'(1);
            j_in    = '0;
         end
         vsks_pkg::ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            if ($signed(cur_ff.key) > $signed(rd_data.key)) begin
               wr_data = rd_data;
            end else begin
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            j_in = j_ff + AW'(1);
            if (jp2 < i_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(jp2);
            end
         end
         vsks_pkg::ST_WB: begin
            wr_en   = 1'b1;
            wr_addr = AW'(i_ff - CW'(1));
            wr_data = cur_ff;
            i_in    = i_ff - CW'(1);
            k_in    = '0;
         end
         vsks_pkg::ST_DRAIN: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff;
            emit_in  = 1'b1;
            pos_in   = vsks_pkg::POS_W'(k_ff);
            lastr_in = (kp1 == count_ff);
            k_in     = k_ff + AW'(1);
            if (kp1 == count_ff) begin
               count_in = '0;
            end
         end
         default: begin
            emit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vsks_pkg::ST_IDLE;
         count_ff <= '0;
         dim_ff   <= vsks_pkg::DIM_RESET;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         emit_ff  <= emit_in;
         if (csr_we) begin
            dim_ff <= csr_wdata;
         end
      end
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      last_pend_ff <= last_pend_in;
      vec_ff       <= vec_in;
      cur_ff       <= cur_in;
      pos_ff       <= pos_in;
      lastr_ff     <= lastr_in;
   end

   // unused components read as zero
   always_comb begin
      for (int c = 0; c < vsks_pkg::NUM_COMPS; c++) begin
         shown[c] = (vsks_pkg::DIM_W'(c) < eff) ? rd_data.comps[c] : '0;
      end
   end

   assign rsp_valid     = emit_ff;
   assign rsp_out_comp0 = shown[0];
   assign rsp_out_comp1 = shown[1];
   assign rsp_out_comp2 = shown[2];
   assign rsp_out_comp3 = shown[3];
   assign rsp_position  = pos_ff;
   assign rsp_last_out  = lastr_ff;

endmodule

FILE: design/vsks_ram.sv
// generic single write port, single read port ram with registered read
module vsks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/vsks_key_unit.sv
// iterative sum key unit, one component per cycle, truncating toward zero
module vsks_key_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [vsks_pkg::DIM_W-1:0]    eff,
   input  vsks_pkg::comp_array_type      comps,
   output logic                          done,
   output vsks_pkg::key_type             key
);

   logic                       busy_ff, busy_in;
   logic [vsks_pkg::DIM_W-1:0] idx_ff, idx_in;
   logic [vsks_pkg::DIM_W-1:0] eff_ff, eff_in;
   vsks_pkg::key_type          sum_ff, sum_in;

   logic signed [vsks_pkg::ACC_W-1:0] shifted;
   logic signed [vsks_pkg::ACC_W-1:0] comp_x;
   logic signed [vsks_pkg::ACC_W-1:0] acc;
   logic                              round_up;

   always_comb begin
      shifted  = {sum_ff, {vsks_pkg::FRAC_W{1'b0}}};
      comp_x   = vsks_pkg::ACC_W'(comps[idx_ff[vsks_pkg::COMP_IDX_W-1:0]]);
      acc      = shifted + comp_x;
      round_up = acc[vsks_pkg::ACC_W-1] && (|acc[vsks_pkg::FRAC_W-1:0]);
   end

   assign done = busy_ff && (idx_ff == eff_ff);
   assign key  = sum_ff;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      eff_in  = eff_ff;
      sum_in  = sum_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         eff_in  = eff;
         sum_in  = '0;
      end else if (busy_ff) begin
         if (idx_ff == eff_ff) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = acc[vsks_pkg::ACC_W-1:vsks_pkg::FRAC_W]
                   + vsks_pkg::KEY_W'(round_up);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      idx_ff <= idx_in;
      eff_ff <= eff_in;
      sum_ff <= sum_in;
   end

endmodule
